[rtl/core/svc_pkg.sv]
`default_nettype none

package svc_pkg;

    localparam int PLAYERS     = 4;
    localparam int WORTH_BITS  = 16;
    localparam int NUM_BITS    = 22;
    localparam int COAL_BITS   = PLAYERS;
    localparam int STORE_DEPTH = 1 << PLAYERS;
    localparam int PLAYER_BITS = $clog2(PLAYERS);
    localparam int SUB_BITS    = PLAYERS - 1;
    localparam int CNT_BITS    = $clog2(PLAYERS + 1);

    function automatic int fact(input int n);
        int r;
        r = 1;
        for (int i = 2; i <= n; i++) begin
            r = r * i;
        end
        return r;
    endfunction

    // largest weight is (PLAYERS-1)! at coalition size one or PLAYERS
    localparam int WT_BITS   = $clog2(fact(PLAYERS - 1) + 1);
    localparam int DIFF_BITS = WORTH_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + WT_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + PLAYERS;

    typedef logic [WT_BITS-1:0] t_wt_tab [PLAYERS+1];

    // weight (k-1)! * (PLAYERS-k)! indexed by coalition size k
    function automatic t_wt_tab build_wt_tab();
        t_wt_tab t;
        t[0] = '0;
        for (int k = 1; k <= PLAYERS; k++) begin
            t[k] = WT_BITS'(fact(k - 1) * fact(PLAYERS - k));
        end
        return t;
    endfunction

    localparam t_wt_tab WEIGHT_TAB = build_wt_tab();

endpackage

`default_nettype wire

[rtl/core/svc_if.sv]
`default_nettype none

interface svc_in_if;
    logic                               valid;
    logic                               ready;
    logic [svc_pkg::COAL_BITS-1:0]      coalition;
    logic signed [svc_pkg::WORTH_BITS-1:0] worth;
    logic                               last;

    modport source (output valid, coalition, worth, last, input ready);
    modport sink   (input valid, coalition, worth, last, output ready);
endinterface

interface svc_out_if;
    logic                               valid;
    logic                               ready;
    logic [svc_pkg::PLAYER_BITS-1:0]    player;
    logic signed [svc_pkg::NUM_BITS-1:0] numerator;
    logic                               final_res;

    modport source (output valid, player, numerator, final_res, input ready);
    modport sink   (input valid, player, numerator, final_res, output ready);
endinterface

`default_nettype wire

[rtl/core/svc_ram.sv]
`default_nettype none

module svc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/shapley_value_calculator_top.sv]
// channel  | dir | payload                          | request meaning
// ---------+-----+----------------------------------+-------------------------------
// i_in     | in  | coalition, worth, last           | one coalition worth to store
// o_out    | out | player, numerator, final_res     | Shapley numerator of a player
//
// a request with last set starts the computation.
// each player walks 2^(PLAYERS-1) coalitions, each in the steps RD_A, RD_B, MUL and ACC,
// through one shared ram read port and one multiplier, then holds its result until taken.
// i_in is not ready while computing or presenting results; reset is synchronous.
`default_nettype none

module shapley_value_calculator_top (
    input  wire     i_clk,
    input  wire     i_rst_n,
    svc_in_if.sink  i_in,
    svc_out_if.source o_out
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD_A = 6'b000010,
        ST_RD_B = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    localparam logic signed [svc_pkg::ACC_BITS-1:0] SAT_HI =
        svc_pkg::ACC_BITS'((64'sd1 <<< (svc_pkg::NUM_BITS - 1)) - 64'sd1);
    localparam logic signed [svc_pkg::ACC_BITS-1:0] SAT_LO =
        svc_pkg::ACC_BITS'(-(64'sd1 <<< (svc_pkg::NUM_BITS - 1)));

    t_state r_state, n_state;
    logic [svc_pkg::PLAYER_BITS-1:0]       r_p;
    logic [svc_pkg::SUB_BITS-1:0]          r_j;
    logic signed [svc_pkg::ACC_BITS-1:0]   r_acc;
    logic [svc_pkg::WT_BITS-1:0]           r_wt;
    logic [svc_pkg::WORTH_BITS-1:0]        r_wa;
    logic signed [svc_pkg::PROD_BITS-1:0]  r_prod;
    logic signed [svc_pkg::NUM_BITS-1:0]   r_num;

    logic                                  in_acc;
    logic                                  out_acc;
    logic [svc_pkg::COAL_BITS-1:0]         pbit;
    logic [svc_pkg::COAL_BITS-1:0]         jw;
    logic [svc_pkg::COAL_BITS-1:0]         coal;
    logic [svc_pkg::COAL_BITS-1:0]         raddr;
    logic [svc_pkg::CNT_BITS-1:0]          cnt;
    logic [svc_pkg::WORTH_BITS-1:0]        rdata;
    logic signed [svc_pkg::DIFF_BITS-1:0]  diff;
    logic signed [svc_pkg::PROD_BITS-1:0]  prod;
    logic signed [svc_pkg::ACC_BITS-1:0]   sum;
    logic signed [svc_pkg::ACC_BITS-1:0]   sat;
    logic                                  last_p;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign last_p  = (r_p == svc_pkg::PLAYER_BITS'(svc_pkg::PLAYERS - 1));

    // coalition r_j with a one inserted at player position r_p
    assign pbit = svc_pkg::COAL_BITS'(1) << r_p;
    assign jw   = svc_pkg::COAL_BITS'(r_j);
    assign coal = ((jw & ~(pbit - 1'b1)) << 1) | (jw & (pbit - 1'b1)) | pbit;

    always_comb begin
        cnt = '0;
        for (int b = 0; b < svc_pkg::COAL_BITS; b++) begin
            cnt = cnt + svc_pkg::CNT_BITS'(coal[b]);
        end
    end

    assign raddr = (r_state == ST_RD_B) ? (coal ^ pbit) : coal;

    svc_ram #(
        .WIDTH (svc_pkg::WORTH_BITS),
        .DEPTH (svc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (i_in.coalition),
        .i_wdata (i_in.worth),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign diff = $signed({r_wa[svc_pkg::WORTH_BITS-1], r_wa})
                - $signed({rdata[svc_pkg::WORTH_BITS-1], rdata});
    assign prod = diff * $signed({1'b0, r_wt});
    assign sum  = r_acc + svc_pkg::ACC_BITS'(r_prod);

    always_comb begin
        if (sum > SAT_HI) begin
            sat = SAT_HI;
        end else if (sum < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = sum;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.last) begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: n_state = ST_RD_B;
            ST_RD_B: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = (r_j == '1) ? ST_OUT : ST_RD_A;
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_state = last_p ? ST_IDLE : ST_RD_A;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p     <= '0;
            r_j     <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in.last) begin
                        r_p   <= '0;
                        r_j   <= '0;
                        r_acc <= '0;
                    end
                end
                ST_ACC: begin
                    r_acc <= sum;
                    r_j   <= r_j + 1'b1;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_p   <= r_p + 1'b1;
                        r_j   <= '0;
                        r_acc <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_A) begin
            r_wt <= svc_pkg::WEIGHT_TAB[cnt];
        end
        if (r_state == ST_RD_B) begin
            r_wa <= rdata;
        end
        if (r_state == ST_MUL) begin
            r_prod <= prod;
        end
        if (r_state == ST_ACC && r_j == '1) begin
            r_num <= svc_pkg::NUM_BITS'(sat);
        end
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.player    = r_p;
    assign o_out.numerator = r_num;
    assign o_out.final_res = last_p;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (!i_in.ready && !o_out.valid))
        else $error("computation did not start after last load");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.final_res) |=> i_in.ready)
        else $error("not idle after final result");

    a_player_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_out.final_res) |=> (r_p == $past(r_p) + 1'b1 && r_acc == '0))
        else $error("player sequence broken");

endmodule

`default_nettype wire
